[design/mpq_pkg.sv]
package mpq_pkg;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DN_SEL,
    ST_DONE
  } heap_state_t;

endpackage

[design/max_priority_queue.sv]
// Bounded max priority queue of signed words held as an array heap.
// Command channel: a word is taken when start is high and busy is low;
// cmd 0 pushes value, cmd 1 pops the largest entry. busy stays high from
// acceptance until the result of that word has been shown.
// Result channel: done is high for one cycle with top_value, queue_empty,
// entry_count and push_dropped; the receiver cannot stall it.
// A pop of an empty queue changes nothing; a push into a full queue is
// dropped and flagged. An empty queue reports the largest signed value.
// A push rises one level at a time and a pop sinks one level at a time;
// a push ends early at the root, and a pop that leaves the queue empty, a
// dropped push and a pop of an empty queue skip the heap walk. The next
// word can be taken in the cycle after done. The single heap memory, read
// once per level, sets the pace of each walk.
// Reset empties the queue; the heap memory itself is not cleared.
module max_priority_queue
  import mpq_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cmd,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] top_value,
  output logic                  queue_empty,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count,
  output logic                  push_dropped
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic q_valid, q_cmd, q_pop, idle;
  logic [DATA_WIDTH-1:0] q_value;

  assign busy = q_valid || !idle;

  mpq_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst, .start, .busy, .cmd, .value,
    .q_pop, .q_valid, .q_cmd, .q_value
  );

  mpq_heap #(
    .CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH), .AW(AW), .CW(CW)
  ) u_heap (
    .clk, .rst, .q_valid, .q_cmd, .q_value, .q_pop, .idle, .done,
    .top_value, .queue_empty, .entry_count, .push_dropped
  );

endmodule

[design/mpq_front.sv]
module mpq_front
  import mpq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  cmd,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic                  q_pop,
  output logic                  q_valid,
  output logic                  q_cmd,
  output logic [DATA_WIDTH-1:0] q_value
);

  // One-entry queue between the command port and the heap engine.
  logic                  full;
  logic                  full_next;
  logic                  qc;
  logic [DATA_WIDTH-1:0] qv;

  always_comb begin
    full_next = full;
    if (q_pop) begin
      full_next = 1'b0;
    end
    if (start && !busy) begin
      full_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      qc <= cmd;
      qv <= value;
    end
  end

  assign q_valid = full;
  assign q_cmd   = qc;
  assign q_value = qv;

endmodule

[design/mpq_heap.sv]
module mpq_heap
  import mpq_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 8,
  parameter int CW         = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic                  q_cmd,
  input  logic [DATA_WIDTH-1:0] q_value,
  output logic                  q_pop,
  output logic                  idle,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] top_value,
  output logic                  queue_empty,
  output logic [CW-1:0]         entry_count,
  output logic                  push_dropped
);

  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;
  logic [DATA_WIDTH-1:0] top_reg;

  heap_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] lim, lim_next;
  logic [DATA_WIDTH-1:0] item, item_next;
  logic drop, drop_next;

  logic          we;
  logic [AW-1:0] wa;
  logic [DATA_WIDTH-1:0] wd;
  logic [AW-1:0] ra_a;
  logic [AW-1:0] ra_b;

  logic [CW-1:0] parent;
  logic [CW:0]   lchild;
  logic [CW:0]   rchild;
  logic          pick_r;
  logic [DATA_WIDTH-1:0] child_v;

  assign parent = (pos - CW'(1)) >> 1;
  assign lchild = {pos, 1'b1};
  assign rchild = lchild + (CW+1)'(1);
  assign pick_r = (rchild < {1'b0, lim}) && ($signed(rd_b) > $signed(rd_a));
  assign child_v = pick_r ? rd_b : rd_a;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    lim_next   = lim;
    item_next  = item;
    drop_next  = drop;
    we   = 1'b0;
    wa   = pos[AW-1:0];
    wd   = item;
    ra_a = parent[AW-1:0];
    ra_b = parent[AW-1:0];
    q_pop = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          drop_next = 1'b0;
          if (q_cmd == CMD_PUSH) begin
            if (count >= CAP) begin
              drop_next  = 1'b1;
              state_next = ST_DONE;
            end else begin
              item_next  = q_value;
              pos_next   = count;
              count_next = count + CW'(1);
              state_next = ST_UP_RD;
            end
          end else if (count == '0) begin
            state_next = ST_DONE;
          end else begin
            ra_a       = AW'(count - CW'(1));
            count_next = count - CW'(1);
            lim_next   = count - CW'(1);
            pos_next   = '0;
            state_next = ST_DN_RD;
          end
        end
      end
      ST_UP_RD: begin
        if (pos == '0) begin
          we = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if ($signed(item) > $signed(rd_a)) begin
          we = 1'b1;
          wd = rd_a;
          pos_next = parent;
          state_next = ST_UP_RD;
        end else begin
          we = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DN_RD: begin
        // The last entry has been read; it sinks from the root.
        item_next = rd_a;
        if (lim == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        if (lchild >= {1'b0, lim}) begin
          we = 1'b1;
          state_next = ST_DONE;
        end else begin
          ra_a = AW'(lchild);
          ra_b = AW'(rchild);
          state_next = ST_DN_SEL;
        end
      end
      ST_DN_SEL: begin
        if ($signed(child_v) > $signed(item)) begin
          we = 1'b1;
          wd = child_v;
          pos_next = pick_r ? CW'(rchild) : CW'(lchild);
          state_next = ST_DN_CMP;
        end else begin
          we = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        ra_a = '0;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // The root is fetched in ST_DONE and shown on the following cycle.
  logic shown;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      drop  <= 1'b0;
      shown <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      drop  <= drop_next;
      shown <= (state == ST_DONE);
    end
    pos  <= pos_next;
    lim  <= lim_next;
    item <= item_next;
  end

  always_comb begin
    top_reg = rd_a;
  end

  assign idle         = (state == ST_IDLE) && !shown;
  assign done         = shown;
  assign top_value    = (count == '0) ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : top_reg;
  assign queue_empty  = (count == '0);
  assign entry_count  = count;
  assign push_dropped = drop;

endmodule

[design/mpq_checker.sv]
module mpq_checker #(
  parameter int CAPACITY = 256,
  parameter int CW       = 9
) (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input logic          queue_empty,
  input logic [CW-1:0] entry_count,
  input logic          push_dropped
);

  a_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> (queue_empty == (entry_count == '0))) else $error("empty flag");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= CW'(CAPACITY))) else $error("count bound");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    (done && push_dropped) |-> (entry_count == CW'(CAPACITY))) else $error("drop");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy after accept");

endmodule

bind max_priority_queue mpq_checker #(
  .CAPACITY(CAPACITY), .CW($clog2(CAPACITY + 1))
) u_mpq_checker (
  .clk, .rst, .start, .busy, .done, .queue_empty, .entry_count, .push_dropped
);
